// File: hw/rtl/pczmp_pkg.sv
`timescale 1ns / 1ps
package pczmp_pkg;

  localparam logic [1:0] CODE_NONE   = 2'd0;
  localparam logic [1:0] CODE_BYPASS = 2'd1;
  localparam logic [1:0] CODE_ALL    = 2'd2;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_PAINT = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam int unsigned WRAP_DEG = 360;
  localparam int unsigned AZ_W     = 10;
  localparam int unsigned SCALE_SH = 4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_PAINT,
    ST_RESPOND
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] zone_start_azimuth;
    logic [8:0] zone_stop_azimuth;
    logic [8:0] zone_start_gate;
    logic [8:0] zone_stop_gate;
    logic [1:0] zone_code;
    logic [2:0] zone_segment;
    logic [8:0] read_azimuth;
    logic [8:0] read_gate;
  } item_t;

  typedef struct packed {
    logic [5:0] cell_value;
    logic       is_read_result;
  } result_t;

  typedef struct packed {
    logic load;
    logic start_clear;
    logic step;
    logic rd_issue;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] item_mode;
    logic       paint_empty;
    logic       walk_last;
    logic       out_free;
  } status_t;

endpackage

// File: hw/rtl/pczmp_ctrl.sv
`timescale 1ns / 1ps
module pczmp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pczmp_pkg::status_t  status_i,
  output pczmp_pkg::cmd_t     cmd_o
);
  import pczmp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.walk_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (status_i.item_mode)
          MODE_CLEAR: state_d = ST_CLEAR;
          MODE_PAINT: state_d = status_i.paint_empty ? ST_RESPOND : ST_PAINT;
          default:    state_d = ST_RESPOND;
        endcase
      end
      ST_CLEAR, ST_PAINT: begin
        if (status_i.walk_last) state_d = ST_RESPOND;
      end
      ST_RESPOND: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DISPATCH: begin
        cmd_o.start_clear = (status_i.item_mode == MODE_CLEAR);
        cmd_o.rd_issue    = (status_i.item_mode == MODE_READ);
      end
      ST_CLEAR, ST_PAINT: begin
        cmd_o.step = 1'b1;
      end
      ST_RESPOND: begin
        cmd_o.resp_load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/pczmp_dpath.sv
`timescale 1ns / 1ps
module pczmp_dpath #(
  parameter int unsigned NUM_RADIALS = 360,
  parameter int unsigned NUM_GATES   = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pczmp_pkg::cmd_t     cmd_i,
  output pczmp_pkg::status_t  status_o,
  input  pczmp_pkg::item_t    in_data_i,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output pczmp_pkg::result_t  out_data_o
);
  import pczmp_pkg::*;

  localparam int unsigned RW        = (NUM_RADIALS > 1) ? $clog2(NUM_RADIALS) : 1;
  localparam int unsigned GW        = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
  localparam int unsigned AW        = RW + GW;
  localparam int unsigned MEM_DEPTH = NUM_RADIALS * (2 ** GW);
  localparam logic [GW-1:0]   GATE_LAST = GW'(NUM_GATES - 1);
  localparam logic [RW-1:0]   RAD_SAT   = RW'(NUM_RADIALS - 1);
  localparam logic [AZ_W-1:0] RAD_LAST  = AZ_W'(NUM_RADIALS - 1);
  localparam logic [AZ_W-1:0] WRAP      = AZ_W'(WRAP_DEG);

  function automatic logic [GW-1:0] sat_gate(input logic [8:0] g);
    sat_gate = (32'(g) >= NUM_GATES) ? GATE_LAST : GW'(g);
  endfunction

  function automatic logic [RW-1:0] sat_rad(input logic [8:0] a);
    sat_rad = (32'(a) >= NUM_RADIALS) ? RAD_SAT : RW'(a);
  endfunction

  logic [1:0]      mem_q [MEM_DEPTH];
  logic [2:0]      cur_seg_q;
  item_t           item_q;
  logic [AZ_W-1:0] j_q, j_end_q;
  logic [GW-1:0]   gate_q, gate_lo_q, gate_hi_q;
  logic            clear_q;
  logic            s1_valid_q;
  logic [AW-1:0]   s1_addr_q;
  logic [1:0]      rdata_q;
  logic            out_valid_q;
  result_t         out_data_q;

  logic [AZ_W-1:0] rad_full, walk_rad, j_stop;
  logic            rad_ok, row_end, walk_last;
  logic [AW-1:0]   walk_addr, read_addr, mem_raddr, mem_waddr;
  logic            mem_re, mem_we, paint_hit;
  logic [1:0]      mem_wdata;
  logic            is_read;

  assign rad_full  = (j_q >= WRAP) ? j_q - WRAP : j_q;
  assign rad_ok    = clear_q || (32'(rad_full) < NUM_RADIALS);
  assign walk_rad  = clear_q ? j_q : rad_full;
  assign walk_addr = {walk_rad[RW-1:0], gate_q};
  assign read_addr = {sat_rad(item_q.read_azimuth), sat_gate(item_q.read_gate)};
  assign row_end   = clear_q ? (gate_q == GATE_LAST) : ((gate_q == gate_hi_q) || !rad_ok);
  assign j_stop    = clear_q ? RAD_LAST : j_end_q;
  assign walk_last = row_end && (j_q == j_stop);

  assign paint_hit = (item_q.zone_code == CODE_ALL)
                  || ((item_q.zone_code == CODE_NONE) && (rdata_q == CODE_BYPASS))
                  || (item_q.zone_code == rdata_q);

  assign mem_re    = (cmd_i.step && !clear_q && rad_ok) || cmd_i.rd_issue;
  assign mem_raddr = cmd_i.rd_issue ? read_addr : walk_addr;
  assign mem_we    = (cmd_i.step && clear_q) || (s1_valid_q && paint_hit);
  assign mem_waddr = clear_q ? walk_addr : s1_addr_q;
  assign mem_wdata = clear_q ? CODE_BYPASS : item_q.zone_code;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_seg_q <= 3'd1;
    end else if (cfg_valid_i) begin
      cur_seg_q <= cfg_data_i;
    end
  end

  // Walk counters cover both the full-map sweep and the zone area.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q        <= '0;
      gate_q     <= '0;
      clear_q    <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.step && !clear_q && rad_ok;
      if (cmd_i.load) begin
        j_q     <= AZ_W'(in_data_i.zone_start_azimuth);
        gate_q  <= sat_gate(in_data_i.zone_start_gate);
        clear_q <= 1'b0;
      end else if (cmd_i.start_clear) begin
        j_q     <= '0;
        gate_q  <= '0;
        clear_q <= 1'b1;
      end else if (cmd_i.step) begin
        if (row_end) begin
          j_q    <= j_q + AZ_W'(1);
          gate_q <= clear_q ? '0 : gate_lo_q;
        end else begin
          gate_q <= gate_q + GW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= walk_addr;
    if (cmd_i.load) begin
      item_q    <= in_data_i;
      gate_lo_q <= sat_gate(in_data_i.zone_start_gate);
      gate_hi_q <= sat_gate(in_data_i.zone_stop_gate);
      if (in_data_i.zone_start_azimuth > in_data_i.zone_stop_azimuth) begin
        j_end_q <= AZ_W'(in_data_i.zone_stop_azimuth) + WRAP;
      end else begin
        j_end_q <= AZ_W'(in_data_i.zone_stop_azimuth);
      end
    end
  end

  assign is_read = (item_q.mode == MODE_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      out_data_q.is_read_result <= is_read;
      out_data_q.cell_value     <= is_read ? {rdata_q, SCALE_SH'(0)} : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.item_mode   = item_q.mode;
  assign status_o.paint_empty = (item_q.zone_segment != cur_seg_q)
                             || (item_q.zone_start_gate > item_q.zone_stop_gate);
  assign status_o.walk_last   = walk_last;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// File: hw/rtl/polar_censor_zone_map_painter.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  in_data_i (item_t)
// out      output     out_valid_o / out_ready_i out_data_o (result_t)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (current segment)
//
// A read passes through a dispatch and a respond state, and its result is registered;
// a paint walks the zone's radials times gates, one cell per cycle through the map
// memory's read-modify-write path, and passes over each radial outside the map.
// A clear sweeps all NUM_RADIALS * NUM_GATES cells, one per cycle.
// After reset the same sweep runs before the first beat is accepted; configuration
// writes are taken throughout.
// A stalled output holds its beat while the next item is already accepted, and
// that item then waits at its result until the stall ends.
module polar_censor_zone_map_painter #(
  parameter int unsigned NUM_RADIALS = 360,
  parameter int unsigned NUM_GATES   = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pczmp_pkg::item_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pczmp_pkg::result_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_data_i
);
  import pczmp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  pczmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pczmp_dpath #(
    .NUM_RADIALS (NUM_RADIALS),
    .NUM_GATES   (NUM_GATES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/pczmp_checker.sv
`timescale 1ns / 1ps
module pczmp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input pczmp_pkg::result_t out_data_o
);
  import pczmp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Output beat changed while stalled.");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted on two consecutive cycles.");

  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_read_result |-> out_data_o.cell_value == 6'd0)
    else $error("Acknowledge beat carries a nonzero cell value.");

  a_read_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_read_result |->
      out_data_o.cell_value[3:0] == 4'd0 && out_data_o.cell_value[5:4] != 2'd3)
    else $error("Read beat holds a code that cannot be stored.");

endmodule

bind polar_censor_zone_map_painter pczmp_checker u_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pczmp_pkg::*;

  localparam int unsigned RADIALS = 360;
  localparam int unsigned GATES = 512;
  localparam int unsigned CELLS = RADIALS * GATES;
  localparam int unsigned PHASE_ITEMS = 105;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CODE_UNMATCHED = 2'd3;

  class cell_map_tracker;
    bit [1:0] codes [CELLS];
    bit [2:0] segment;
    result_t expected_q[$];
    int unsigned failures;

    function new();
      wipe();
      segment = 3'd1;
      failures = 0;
    endfunction

    function void wipe();
      foreach (codes[i]) codes[i] = CODE_BYPASS;
    endfunction

    function void paint(item_t it);
      int unsigned j, g, az_end, lo, hi, rad;
      bit [1:0] cur;
      if (it.zone_start_gate > it.zone_stop_gate) return;
      lo = (32'(it.zone_start_gate) >= GATES) ? GATES - 1 : 32'(it.zone_start_gate);
      hi = (32'(it.zone_stop_gate) >= GATES) ? GATES - 1 : 32'(it.zone_stop_gate);
      az_end = 32'(it.zone_stop_azimuth);
      if (it.zone_start_azimuth > it.zone_stop_azimuth) az_end += WRAP_DEG;
      for (j = 32'(it.zone_start_azimuth); j <= az_end; j++) begin
        rad = (j >= WRAP_DEG) ? j - WRAP_DEG : j;
        if (rad >= RADIALS) continue;
        for (g = lo; g <= hi; g++) begin
          cur = codes[rad * GATES + g];
          if (it.zone_code == CODE_ALL || (it.zone_code == CODE_NONE && cur == CODE_BYPASS) ||
              it.zone_code == cur) begin
            codes[rad * GATES + g] = it.zone_code;
          end
        end
      end
    endfunction

    function void note_item(item_t it);
      result_t r;
      int unsigned rad, g;
      r = '0;
      case (it.mode)
        MODE_CLEAR: wipe();
        MODE_PAINT: begin
          if (it.zone_segment == segment) paint(it);
        end
        MODE_READ: begin
          rad = (32'(it.read_azimuth) >= RADIALS) ? RADIALS - 1 : 32'(it.read_azimuth);
          g = (32'(it.read_gate) >= GATES) ? GATES - 1 : 32'(it.read_gate);
          r.cell_value = {codes[rad * GATES + g], 4'b0000};
          r.is_read_result = 1'b1;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void report(string what, result_t want, result_t got);
      failures++;
      if (failures <= 10) begin
        $display("%0t: %s: expected value %0d read %0b, got value %0d read %0b", $time, what,
                 want.cell_value, want.is_read_result, got.cell_value, got.is_read_result);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.cell_value !== want.cell_value || got.is_read_result !== want.is_read_result) begin
        report("result mismatch", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_data = 3'd0;

  cell_map_tracker tracker;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0] stall_pos = 4'd0;
  bit gaps_on;
  int unsigned burst_left;
  int unsigned hot_az, hot_g, zone_az, zone_g, zone_span, zone_depth;

  polar_censor_zone_map_painter #(
    .NUM_RADIALS(RADIALS),
    .NUM_GATES(GATES)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    stall_pos <= stall_pos + 4'd1;
    out_ready <= stall_pat[stall_pos];
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) tracker.note_item(in_data);
    if (out_valid && out_ready) tracker.check_result(out_data);
    if (cfg_valid && cfg_ready) tracker.segment = cfg_data;
  end

  function automatic item_t noise(logic [1:0] mode);
    logic [63:0] raw;
    item_t it;
    raw = {$urandom(), $urandom()};
    it = raw[$bits(item_t)-1:0];
    it.mode = mode;
    return it;
  endfunction

  function automatic item_t zone(int unsigned saz, int unsigned eaz, int unsigned sg,
                                 int unsigned eg, logic [1:0] code, logic [2:0] seg);
    item_t it;
    it = noise(MODE_PAINT);
    it.zone_start_azimuth = 9'(saz);
    it.zone_stop_azimuth = 9'(eaz);
    it.zone_start_gate = 9'(sg);
    it.zone_stop_gate = 9'(eg);
    it.zone_code = code;
    it.zone_segment = seg;
    return it;
  endfunction

  function automatic item_t peek(int unsigned raz, int unsigned rg);
    item_t it;
    it = noise(MODE_READ);
    it.read_azimuth = 9'(raz);
    it.read_gate = 9'(rg);
    return it;
  endfunction

  function void pick_hot();
    hot_az = ($urandom_range(0, 4) == 0) ? $urandom_range(354, 359) : $urandom_range(0, 359);
    hot_g = $urandom_range(0, 491);
    zone_az = hot_az;
    zone_g = hot_g;
    zone_span = 0;
    zone_depth = 0;
  endfunction

  // Zones cluster around a moving hot spot so that they overlap and most reads land on
  // freshly painted cells.
  function item_t random_item(bit force_clear);
    item_t it;
    int unsigned roll;
    if (force_clear) return noise(MODE_CLEAR);
    if ($urandom_range(0, 19) == 0) pick_hot();
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      it = noise(MODE_PAINT);
      zone_az = (hot_az + $urandom_range(0, 6)) % RADIALS;
      zone_span = $urandom_range(0, 4);
      zone_g = hot_g + $urandom_range(0, 12);
      zone_depth = $urandom_range(0, 8);
      it.zone_start_azimuth = 9'(zone_az);
      it.zone_stop_azimuth = 9'((zone_az + zone_span) % RADIALS);
      it.zone_start_gate = 9'(zone_g);
      if ($urandom_range(0, 9) == 0 && zone_g >= 4) begin
        it.zone_stop_gate = 9'(zone_g - $urandom_range(1, 4));
      end else begin
        it.zone_stop_gate = 9'(zone_g + zone_depth);
      end
      it.zone_code = ($urandom_range(0, 9) == 0) ? CODE_UNMATCHED : 2'($urandom_range(0, 2));
      it.zone_segment = (roll < 37) ? tracker.segment : 3'($urandom_range(0, 7));
    end else if (roll < 92) begin
      if ($urandom_range(0, 3) != 0) begin
        it = peek((zone_az + $urandom_range(0, zone_span)) % RADIALS,
                  zone_g + $urandom_range(0, zone_depth));
      end else begin
        it = peek($urandom_range(0, 511), $urandom_range(0, 511));
      end
    end else begin
      it = noise(MODE_UNUSED);
    end
    return it;
  endfunction

  task automatic send(item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_segment(logic [2:0] seg);
    cfg_valid <= 1'b1;
    cfg_data <= seg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [2:0] seg;
    tracker = new();
    gaps_on = 1'b1;
    burst_left = 0;
    pick_hot();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_segment(3'd0);

    send(peek(0, 0));
    send(peek(511, 511));
    send(zone(0, 0, 0, 511, CODE_ALL, 3'd0));
    send(peek(0, 0));
    send(peek(0, 511));
    send(zone(0, 0, 0, 511, CODE_NONE, 3'd0));
    send(peek(0, 300));
    send(zone(0, 359, 0, 3, CODE_NONE, 3'd0));
    send(peek(100, 2));
    send(peek(0, 2));
    send(zone(100, 100, 0, 3, CODE_BYPASS, 3'd0));
    send(peek(100, 1));
    send(zone(0, 359, 0, 3, CODE_UNMATCHED, 3'd0));
    send(peek(200, 3));
    send(zone(358, 1, 10, 12, CODE_ALL, 3'd0));
    send(peek(359, 11));
    send(peek(2, 11));
    send(zone(50, 60, 20, 30, CODE_ALL, 3'd5));
    send(peek(55, 25));
    send(zone(70, 71, 40, 30, CODE_ALL, 3'd0));
    send(peek(70, 35));
    // A start of 511 and a stop of 400 walks radials past the end of the map.
    send(zone(511, 400, 5, 5, CODE_ALL, 3'd0));
    send(peek(151, 5));
    send(peek(400, 5));
    send(zone(400, 410, 6, 6, CODE_ALL, 3'd0));
    send(peek(45, 6));
    send(noise(MODE_UNUSED));
    send(noise(MODE_CLEAR));
    send(peek(359, 11));
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: seg = 3'd7;
        1: seg = 3'd0;
        2: seg = 3'd4;
        3: seg = 3'd1;
        default: seg = 3'($urandom_range(0, 7));
      endcase
      write_segment(seg);
      case (phase)
        0, 1: stall_pat = 16'hFFFF;
        3: stall_pat = 16'($urandom() & $urandom()) | 16'h0001;
        default: stall_pat = 16'($urandom()) | 16'h0001;
      endcase
      gaps_on = (phase != 1);
      burst_left = 0;
      pick_hot();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send(random_item(phase == 2 && n == 50));
      end
      settle();
    end

    repeat (50) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #48000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
